### hdl/eps_pkg.sv
// Shared types, constants and the exp2 mantissa table for the exponential-pitch oscillator.
package eps_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int EXP_TABLE_BITS = 8;

  localparam int SAMPLE_W  = 16;
  localparam int BASE_W    = 20;
  localparam int LEVEL_W   = 2;
  localparam int FRAC_BITS = 30;
  localparam int MANT_W    = FRAC_BITS + 1;
  localparam int U_W       = SAMPLE_W + 1;
  localparam int EXPO_W    = U_W + 2;
  localparam int EXPO_FRAC = SAMPLE_W - 1;
  localparam int SHIFT_W   = EXPO_W - EXPO_FRAC;
  localparam int MAX_SHIFT = 12;
  localparam int PROD_W    = BASE_W + MANT_W;
  localparam int SUM_A_W   = PROD_W + MAX_SHIFT + 1;
  localparam int SUM_B_W   = FRAC_BITS + PHASE_BITS;
  localparam int SUM_W     = (SUM_A_W > SUM_B_W) ? SUM_A_W : SUM_B_W;

  localparam int EXP_ROM_DEPTH = 1 << EXP_TABLE_BITS;
  localparam int ROOT_COUNT    = 12;

  localparam logic [BASE_W-1:0] BASE_STEP_RESET = BASE_W'(178957);

  localparam logic signed [LEVEL_W-1:0] LEVEL_POS = 2'sb01;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NEG = 2'sb11;

  // round(2^(2^-j) * 2^30) for j = 1 .. 12
  localparam logic [MANT_W-1:0] ROOT_Q30 [ROOT_COUNT] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544
  };

  typedef logic [MANT_W-1:0] exp_rom_t [EXP_ROM_DEPTH];

  typedef struct packed {
    logic [PROD_W-1:0]  prod;
    logic [SHIFT_W-1:0] shift;
  } eps_prod_t;

  // 2^(i / 2^EXP_TABLE_BITS) in Q.30, built as a rounded product of square roots
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] m;
    for (int i = 0; i < EXP_ROM_DEPTH; i++) begin
      m = 64'd1 << FRAC_BITS;
      for (int j = 1; j <= EXP_TABLE_BITS && j <= ROOT_COUNT; j++) begin
        if (((i >> (EXP_TABLE_BITS - j)) & 1) != 0) begin
          m = (m * 64'(ROOT_Q30[j-1]) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
      end
      rom[i] = m[MANT_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP2_ROM = build_exp_rom();

endpackage

### hdl/eps_step_calc.sv
// Exponent formation, exp2 table lookup and scaling of the base phase step.
module eps_step_calc (
  input  logic signed [eps_pkg::SAMPLE_W-1:0] sample,
  input  logic        [eps_pkg::BASE_W-1:0]   base_step,
  output eps_pkg::eps_prod_t                  prod_o
);
  import eps_pkg::*;

  logic [U_W-1:0]            u;
  logic [EXPO_W-1:0]         expo;
  logic [EXP_TABLE_BITS-1:0] rom_idx;
  logic [MANT_W-1:0]         mant;

  // u = 1 - x in Q.15, e = 6u
  assign u       = U_W'(1 << EXPO_FRAC) - {sample[SAMPLE_W-1], sample};
  assign expo    = ({2'b00, u} << 2) + ({2'b00, u} << 1);
  assign rom_idx = expo[EXPO_FRAC-1 -: EXP_TABLE_BITS];
  assign mant    = EXP2_ROM[rom_idx];

  assign prod_o.shift = expo[EXPO_W-1:EXPO_FRAC];
  assign prod_o.prod  = PROD_W'(base_step) * PROD_W'(mant);

endmodule

### hdl/exp_pitch_square_oscillator_core.sv
// Top level of the exponential-pitch square-wave oscillator.
//
// One input transfer is one audio tick carrying a signed Q1.15 pitch control
// sample; each tick yields exactly one result transfer with the square level
// (+1 or -1) and a gate bit that is always 1. Pitch is 2 * 2^(6*(1-x)) Hz,
// scaled from the 2 Hz phase step held in the configuration register.
// The level reflects the phase before this tick's step is added: +1 while
// the phase lies strictly above half a turn, -1 otherwise.
// A sample passes through the input register, the product register and
// the result register before it appears on the result port.
// Throughput: one transfer per cycle, sustained while out_stall is low; the
// pipeline is three deep and each stage advances whenever the stage after
// it is empty or moving. A stall on the result side holds the result and
// backs up through the stages; in_stall rises only once every stage is full.
// Reset clears all valids and the phase accumulator and loads the base step
// with its 2 Hz default. Write the register only while the block is idle.
module exp_pitch_square_oscillator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic        [eps_pkg::BASE_W-1:0]   cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [eps_pkg::SAMPLE_W-1:0] in_control_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [eps_pkg::LEVEL_W-1:0]  out_square_level,
  output logic                                out_gate
);
  import eps_pkg::*;

  // configuration
  logic [BASE_W-1:0] base_step_r;

  // stage A: captured sample
  logic                       a_valid_r, a_valid_nxt;
  logic signed [SAMPLE_W-1:0] a_sample_r;

  // stage B: scaled product and octave shift
  logic      b_valid_r, b_valid_nxt;
  eps_prod_t b_prod_r;
  eps_prod_t prod_calc;

  // result stage and phase
  logic                       out_valid_r, out_valid_nxt;
  logic signed [LEVEL_W-1:0]  level_r;
  logic [PHASE_BITS-1:0]      phase_accum_r, phase_accum_nxt;

  // handshake between stages
  logic out_load;
  logic b_ready;
  logic a_ready;

  // step arithmetic
  logic [SUM_W-1:0]      shifted;
  logic [SUM_W-1:0]      rounded;
  logic [PHASE_BITS-1:0] step;
  logic                  above_half;

  eps_step_calc u_step_calc (
    .sample    (a_sample_r),
    .base_step (base_step_r),
    .prod_o    (prod_calc)
  );

  // Advance a stage when the next one is empty or is being emptied this cycle
  assign out_load = b_valid_r && (!out_valid_r || !out_stall);
  assign b_ready  = !b_valid_r || out_load;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_stall = !a_ready;

  // step = (base * m * 2^n + half) >> 30, wrapped to the phase width
  assign shifted = SUM_W'(b_prod_r.prod) << b_prod_r.shift;
  assign rounded = shifted + (SUM_W'(1) << (FRAC_BITS - 1));
  assign step    = rounded[FRAC_BITS +: PHASE_BITS];

  // Exactly half a turn counts as the low half
  assign above_half = phase_accum_r[PHASE_BITS-1] && (|phase_accum_r[PHASE_BITS-2:0]);

  always_comb begin
    a_valid_nxt     = a_ready ? in_valid : a_valid_r;
    b_valid_nxt     = b_ready ? a_valid_r : b_valid_r;
    out_valid_nxt   = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    phase_accum_nxt = out_load ? phase_accum_r + step : phase_accum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r   <= BASE_STEP_RESET;
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_accum_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        base_step_r <= cfg_wr_data;
      end
      a_valid_r     <= a_valid_nxt;
      b_valid_r     <= b_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      phase_accum_r <= phase_accum_nxt;
    end
  end

  // Payload registers: sample and product load whenever their stage is ready, the level only on a result transfer
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_sample_r <= in_control_sample;
    end
    if (b_ready) begin
      b_prod_r <= prod_calc;
    end
    if (out_load) begin
      level_r <= above_half ? LEVEL_POS : LEVEL_NEG;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_square_level = level_r;
  assign out_gate         = 1'b1;

`ifndef SYNTH
  a_level_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_square_level == LEVEL_POS || out_square_level == LEVEL_NEG))
    else $error("square level is neither +1 nor -1");

  a_phase_moves_on_load : assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(phase_accum_r))
    else $error("phase moved without a result transfer");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && b_valid_r && out_valid_r))
    else $error("input stalled while a stage was free");

  a_reset_clears_output : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule
